// File: hdl/catan_pkg.sv
// Package with the shared types, constants and arithmetic for the complex arctangent core.
package catan_pkg;
    localparam int InWidth    = 16;
    localparam int FracBits   = 13;
    localparam int Stages     = 16;
    localparam int WideWidth  = 48;
    localparam int AngWidth   = 28;
    localparam int NormBit    = 40;
    localparam int RealLimit  = 12868;

    localparam logic signed [AngWidth-1:0] HalfPiQ24 = 28'sd26353589;
    localparam logic signed [AngWidth-1:0] Ln2Q24    = 28'sd11629080;

    typedef logic signed [WideWidth-1:0] t_wide;
    typedef logic signed [AngWidth-1:0]  t_ang;

    typedef struct packed {
        t_wide cx;
        t_wide cy;
        t_ang  cz;
        t_wide hx;
        t_wide hy;
        t_ang  hz;
        logic signed [7:0] k;
        logic  branch;
        logic  branch_pos;
    } t_work;

    function automatic t_ang circ_angle(input logic [5:0] i);
        case (i)
            6'd0: circ_angle = 28'sd13176795;
            6'd1: circ_angle = 28'sd7778716;
            6'd2: circ_angle = 28'sd4110060;
            6'd3: circ_angle = 28'sd2086331;
            6'd4: circ_angle = 28'sd1047214;
            6'd5: circ_angle = 28'sd524117;
            6'd6: circ_angle = 28'sd262123;
            6'd7: circ_angle = 28'sd131069;
            default: circ_angle = (i <= 6'd24) ? (t_ang'(1) <<< (6'd24 - i)) : '0;
        endcase
    endfunction

    function automatic t_ang hyp_angle(input logic [5:0] i);
        case (i)
            6'd0: hyp_angle = '0;
            6'd1: hyp_angle = 28'sd9215828;
            6'd2: hyp_angle = 28'sd4285116;
            6'd3: hyp_angle = 28'sd2108178;
            6'd4: hyp_angle = 28'sd1049945;
            6'd5: hyp_angle = 28'sd524459;
            6'd6: hyp_angle = 28'sd262165;
            6'd7: hyp_angle = 28'sd131075;
            default: hyp_angle = (i <= 6'd24) ? (t_ang'(1) <<< (6'd24 - i)) : '0;
        endcase
    endfunction

    // Shift for hyperbolic step s, with shifts 4 and 13 repeated.
    function automatic logic [5:0] hyp_shift(input int s);
        int i;
        i = s + 1;
        if (s >= 4) begin
            i = i - 1;
        end
        if (s >= 14) begin
            i = i - 1;
        end
        hyp_shift = 6'(i);
    endfunction
endpackage

// File: hdl/catan_prep.sv
// Front end: squares, P and M, normalization and CORDIC start values.
module catan_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [catan_pkg::InWidth-1:0] i_x,
    input  logic signed [catan_pkg::InWidth-1:0] i_y,
    output logic                          o_valid,
    output catan_pkg::t_work              o_work
);
    import catan_pkg::*;

    logic        r_v1;
    t_wide       r_x, r_y, r_x2, r_y2;
    logic        r_v2;
    t_wide       r_p, r_m, r_ax, r_ay;
    logic        r_v3;
    t_work       r_w;
    logic [5:0]  lp, lm;
    t_wide       pn, mn, ax, ay;
    t_work       n_w;
    logic signed [31:0] x2_w, y2_w;

    assign x2_w = i_x * i_x;
    assign y2_w = i_y * i_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= t_wide'(i_x);
            r_y  <= t_wide'(i_y);
            r_x2 <= t_wide'(x2_w);
            r_y2 <= t_wide'(y2_w);
            r_p  <= r_x2 + r_y2 + (t_wide'(1) <<< 26) + (r_y <<< 14);
            r_m  <= r_x2 + r_y2 + (t_wide'(1) <<< 26) - (r_y <<< 14);
            r_ax <= (t_wide'(1) <<< 26) - r_x2 - r_y2;
            r_ay <= r_x <<< 14;
            r_w  <= n_w;
        end
    end

    always_comb begin
        lp = '0;
        lm = '0;
        for (int b = 0; b < 40; b++) begin
            if (r_p[b]) lp = 6'(b);
            if (r_m[b]) lm = 6'(b);
        end
        pn = r_p <<< (6'(NormBit) - lp);
        mn = r_m <<< (6'(NormBit) - lm);
        n_w = '0;
        n_w.branch     = (r_m <= 0) || (r_p <= 0);
        n_w.branch_pos = (r_m <= 0);
        n_w.k  = 8'($signed({2'b0, lp}) - $signed({2'b0, lm}));
        n_w.hx = pn + mn;
        n_w.hy = pn - mn;
        ax = r_ax;
        ay = r_ay;
        if (ax < 0) begin
            if (ay >= 0) begin
                n_w.cx = ay; n_w.cy = -ax; n_w.cz = HalfPiQ24;
            end else begin
                n_w.cx = -ay; n_w.cy = ax; n_w.cz = -HalfPiQ24;
            end
        end else begin
            n_w.cx = ax; n_w.cy = ay; n_w.cz = '0;
        end
    end

    assign o_valid = r_v3;
    assign o_work  = r_w;
endmodule

// File: hdl/catan_cordic.sv
// Unrolled circular and hyperbolic vectoring CORDIC stages, one register per stage.
module catan_cordic (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  catan_pkg::t_work i_work,
    output logic             o_valid,
    output catan_pkg::t_work o_work
);
    import catan_pkg::*;

    t_work r_st [Stages];
    logic  r_v  [Stages];
    t_work n_st [Stages];

    always_comb begin
        for (int s = 0; s < Stages; s++) begin
            t_work w;
            logic [5:0] hi;
            w = (s == 0) ? i_work : r_st[s-1];
            n_st[s] = w;
            if (w.cy >= 0) begin
                n_st[s].cx = w.cx + (w.cy >>> s);
                n_st[s].cy = w.cy - (w.cx >>> s);
                n_st[s].cz = w.cz + circ_angle(6'(s));
            end else begin
                n_st[s].cx = w.cx - (w.cy >>> s);
                n_st[s].cy = w.cy + (w.cx >>> s);
                n_st[s].cz = w.cz - circ_angle(6'(s));
            end
            hi = hyp_shift(s);
            if (w.hy >= 0) begin
                n_st[s].hx = w.hx - (w.hy >>> hi);
                n_st[s].hy = w.hy - (w.hx >>> hi);
                n_st[s].hz = w.hz + hyp_angle(hi);
            end else begin
                n_st[s].hx = w.hx + (w.hy >>> hi);
                n_st[s].hy = w.hy + (w.hx >>> hi);
                n_st[s].hz = w.hz - hyp_angle(hi);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < Stages; s++) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= (s == 0) ? i_valid : r_v[s-1];
            end
            if (i_en) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_valid = r_v[Stages-1];
    assign o_work  = r_st[Stages-1];
endmodule

// File: hdl/catan_post.sv
// Back end: exponent correction, rounding, clamping and branch-point handling.
module catan_post (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  catan_pkg::t_work i_work,
    output logic             o_valid,
    output logic signed [14:0] o_re,
    output logic signed [15:0] o_im,
    output logic             o_sat
);
    import catan_pkg::*;

    logic              r_v1;
    logic signed [35:0] r_l;
    t_ang              r_a;
    logic              r_br, r_brp;
    logic              r_v2;
    logic signed [14:0] r_re;
    logic signed [15:0] r_im;
    logic              r_sat;
    logic signed [35:0] re_w, im_w;
    logic signed [14:0] n_re;
    logic signed [15:0] n_im;
    logic              n_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l   <= (36'(i_work.hz) <<< 1) + 36'(i_work.k) * 36'(Ln2Q24);
            r_a   <= i_work.cz;
            r_br  <= i_work.branch;
            r_brp <= i_work.branch_pos;
            r_re  <= n_re;
            r_im  <= n_im;
            r_sat <= n_sat;
        end
    end

    always_comb begin
        re_w = (36'(r_a) + 36'sd2048) >>> 12;
        im_w = (r_l + 36'sd4096) >>> 13;
        n_sat = 1'b0;
        if (re_w > 36'(RealLimit)) n_re = 15'(RealLimit);
        else if (re_w < -36'(RealLimit)) n_re = -15'(RealLimit);
        else n_re = 15'(re_w);
        if (im_w > 36'sd32767) begin
            n_im = 16'sd32767; n_sat = 1'b1;
        end else if (im_w < -36'sd32768) begin
            n_im = -16'sd32768; n_sat = 1'b1;
        end else begin
            n_im = 16'(im_w);
        end
        if (r_br) begin
            n_re  = '0;
            n_im  = r_brp ? 16'sd32767 : -16'sd32768;
            n_sat = 1'b1;
        end
    end

    assign o_valid = r_v2;
    assign o_re    = r_re;
    assign o_im    = r_im;
    assign o_sat   = r_sat;
endmodule

// File: hdl/complex_arctangent_core.sv
// Top level of the complex arctangent core: pipeline and output register.
// Computes catan(z) for z in Q2.13, one request per cycle while the output is not
// stalled. The pipeline has three front-end stages for squares and normalization,
// sixteen CORDIC stages, two back-end stages and one output register.
// The pipeline advances whenever the output register is empty or being taken.
module complex_arctangent_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // real_in[15:0], imag_in[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // real_out[14:0], imag_out[30:15], saturated[31]
);
    import catan_pkg::*;

    logic  en, v_prep, v_cor, v_post, sat;
    t_work w_prep, w_cor;
    logic signed [14:0] re;
    logic signed [15:0] im;
    logic        r_valid;
    logic [31:0] r_data;

    assign en            = !r_valid || m_axis_tready;
    assign s_axis_tready = en;

    catan_prep u_prep (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_axis_tvalid),
        .i_x(s_axis_tdata[15:0]), .i_y(s_axis_tdata[31:16]),
        .o_valid(v_prep), .o_work(w_prep)
    );

    catan_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(v_prep), .i_work(w_prep),
        .o_valid(v_cor), .o_work(w_cor)
    );

    catan_post u_post (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(v_cor), .i_work(w_cor),
        .o_valid(v_post), .o_re(re), .o_im(im), .o_sat(sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= v_post;
        end
        if (en) begin
            r_data <= {sat, im, re};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
endmodule

// File: hdl/catan_checker.sv
// Port-level checker for the complex arctangent core, bound to the top level.
module catan_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) <= 15'sd12868 &&
                           $signed(m_axis_tdata[14:0]) >= -15'sd12868))
        else $error("real part out of range");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[31] |-> (m_axis_tdata[30:15] == 16'h7fff ||
                                               m_axis_tdata[30:15] == 16'h8000))
        else $error("flag without clipped value");
endmodule

bind complex_arctangent_core catan_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// File: tb/tb_top.sv
// Self-checking testbench for the complex arctangent core with a bit-exact predictor.
module tb_top;
    import catan_pkg::*;

    localparam int  RandItems = 1225;
    localparam int  CycleLimit = 400000;
    localparam int  DrainCycles = 40;

    typedef struct {
        logic signed [14:0] re;
        logic signed [15:0] im;
        logic               sat;
    } t_catan_res;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 typed;
        t_catan_res         res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    t_catan_res  catan_expected[$];
    int          errors = 0;
    int          cycles = 0;
    int          sent = 0;
    int          received = 0;
    int          saturations = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_request = 0;

    complex_arctangent_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint circ_step_angle(int i);
        longint tab[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069};
        if (i < 8) return tab[i];
        if (i <= 24) return longint'(1) << (24 - i);
        return 0;
    endfunction

    function automatic longint hyp_step_angle(int i);
        longint tab[8] = '{0, 9215828, 4285116, 2108178, 1049945, 524459, 262165, 131075};
        if (i < 8) return tab[i];
        if (i <= 24) return longint'(1) << (24 - i);
        return 0;
    endfunction

    function automatic int top_bit(longint v);
        int p;
        p = 0;
        while (p < 62 && (v >>> (p + 1)) != 0) p++;
        return p;
    endfunction

    function automatic longint vector_atan2(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 26353589;
            end else begin
                t = x; x = -y; y = t; z = -26353589;
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += circ_step_angle(i);
            end else begin
                x = x - ys; y = y + xs; z -= circ_step_angle(i);
            end
        end
        return z;
    endfunction

    function automatic longint vector_atanh(longint y, longint x);
        longint z, xs, ys;
        int i;
        bit rep;
        z = 0;
        i = 1;
        rep = 0;
        for (int s = 0; s < 16; s++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x - ys; y = y - xs; z += hyp_step_angle(i);
            end else begin
                x = x + ys; y = y + xs; z -= hyp_step_angle(i);
            end
            if ((i == 4 || i == 13) && !rep) begin
                rep = 1;
            end else begin
                rep = 0;
                i++;
            end
        end
        return z;
    endfunction

    function automatic t_catan_res predict_catan(logic signed [15:0] xin,
                                                 logic signed [15:0] yin);
        t_catan_res r;
        longint x, y, one, x2, y2, p, m, a, pn, mn, k, l, re, im;
        int lp, lm;
        x = xin;
        y = yin;
        one = longint'(1) << 26;
        x2 = x * x;
        y2 = y * y;
        p = x2 + y2 + one + 2 * (y <<< 13);
        m = x2 + y2 + one - 2 * (y <<< 13);
        r.sat = 1'b0;
        if (m <= 0 || p <= 0) begin
            re = 0;
            im = (m <= 0) ? 32767 : -32768;
            r.sat = 1'b1;
        end else begin
            a = vector_atan2(2 * (x <<< 13), one - x2 - y2);
            lp = top_bit(p);
            lm = top_bit(m);
            pn = p << (40 - lp);
            mn = m << (40 - lm);
            k = lp - lm;
            l = 2 * vector_atanh(pn - mn, pn + mn) + k * 11629080;
            re = (a + 2048) >>> 12;
            if (re > 12868) re = 12868;
            if (re < -12868) re = -12868;
            im = (l + 4096) >>> 13;
            if (im > 32767) begin
                im = 32767; r.sat = 1'b1;
            end
            if (im < -32768) begin
                im = -32768; r.sat = 1'b1;
            end
        end
        r.re = re[14:0];
        r.im = im[15:0];
        return r;
    endfunction

    task automatic send_request(logic signed [15:0] x, logic signed [15:0] y, bit typed,
                                t_catan_res typed_res);
        t_catan_res r;
        t_catan_res p;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        p = predict_catan(x, y);
        if (typed) begin
            r = typed_res;
        end else begin
            r = p;
        end
        if (typed && (r.re !== p.re || r.im !== p.im || r.sat !== p.sat)) begin
            $display("%0t: table row (%0d,%0d) disagrees with predictor", $realtime, x, y);
            errors++;
        end
        catan_expected.push_back(r);
        sent++;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            m_axis_tready <= 1'b0;
            hold_request  <= hold_request - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_catan_res e;
        logic signed [14:0] got_re;
        logic signed [15:0] got_im;
        logic               got_sat;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles", cycles);
            $display("[complex_arctangent_core] ERROR");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_re  = m_axis_tdata[14:0];
            got_im  = m_axis_tdata[30:15];
            got_sat = m_axis_tdata[31];
            received++;
            if (got_sat) saturations++;
            if (catan_expected.size() == 0) begin
                $display("%0t: unexpected result re=%0d im=%0d sat=%0b", $realtime,
                         got_re, got_im, got_sat);
                errors++;
            end else begin
                e = catan_expected.pop_front();
                if (got_re !== e.re) begin
                    $display("%0t: real_out expected %0d actual %0d", $realtime, e.re, got_re);
                    errors++;
                end
                if (got_im !== e.im) begin
                    $display("%0t: imag_out expected %0d actual %0d", $realtime, e.im, got_im);
                    errors++;
                end
                if (got_sat !== e.sat) begin
                    $display("%0t: saturated expected %0b actual %0b", $realtime, e.sat,
                             got_sat);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_stim_row  rows[$];
        t_catan_res none;
        int         sel, phase;
        logic signed [15:0] rx, ry;
        none = '{re: '0, im: '0, sat: 1'b0};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        rows.push_back('{16'sd0, 16'sd8192, 1'b1, '{15'sd0, 16'sd32767, 1'b1}});
        rows.push_back('{16'sd0, -16'sd8192, 1'b1, '{15'sd0, -16'sd32768, 1'b1}});
        rows.push_back('{16'sd0, 16'sd0, 1'b0, none});
        rows.push_back('{16'sd32767, 16'sd32767, 1'b0, none});
        rows.push_back('{-16'sd32768, -16'sd32768, 1'b0, none});
        rows.push_back('{16'sd32767, -16'sd32768, 1'b0, none});
        rows.push_back('{-16'sd32768, 16'sd32767, 1'b0, none});
        rows.push_back('{16'sd0, 16'sd16384, 1'b0, none});
        rows.push_back('{16'sd0, -16'sd16384, 1'b0, none});
        rows.push_back('{16'sd1, 16'sd8192, 1'b0, none});
        rows.push_back('{-16'sd1, 16'sd8192, 1'b0, none});
        rows.push_back('{16'sd1, -16'sd8192, 1'b0, none});
        rows.push_back('{16'sd0, 16'sd8191, 1'b0, none});
        rows.push_back('{16'sd0, 16'sd8193, 1'b0, none});
        rows.push_back('{16'sd0, -16'sd8193, 1'b0, none});
        rows.push_back('{16'sd8192, 16'sd0, 1'b0, none});
        rows.push_back('{-16'sd8192, 16'sd0, 1'b0, none});
        rows.push_back('{16'sd32767, 16'sd0, 1'b0, none});
        rows.push_back('{-16'sd32768, 16'sd0, 1'b0, none});
        rows.push_back('{16'sd5793, 16'sd5793, 1'b0, none});
        rows.push_back('{16'sd0, 16'sd32767, 1'b0, none});
        rows.push_back('{16'sd0, -16'sd32768, 1'b0, none});
        rows.push_back('{16'sd1, 16'sd0, 1'b0, none});
        rows.push_back('{-16'sd1, -16'sd1, 1'b0, none});
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (rows[n]) send_request(rows[n].x, rows[n].y, rows[n].typed, rows[n].res);
        for (int n = 0; n < RandItems; n++) begin
            phase = n / 245;
            case (phase)
                0: begin
                    idle_pct = 0;  stall_pct = 0;
                end
                1: begin
                    idle_pct = 60; stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;  stall_pct = 60;
                end
                3: begin
                    idle_pct = 28; stall_pct = 28;
                end
                default: begin
                    idle_pct = 0;  stall_pct = 10;
                end
            endcase
            if (n % 245 == 100 && phase >= 4) hold_request = 300;
            sel = $urandom_range(9);
            if (sel < 4) begin
                rx = 16'($urandom);
                ry = 16'($urandom);
            end else if (sel < 7) begin
                rx = $signed(16'($urandom_range(64))) - 16'sd32;
                ry = ($urandom_range(1) ? 16'sd8192 : -16'sd8192)
                     + $signed(16'($urandom_range(64))) - 16'sd32;
                if ($urandom_range(3) == 0) rx = '0;
            end else begin
                rx = $signed(16'($urandom_range(24576))) - 16'sd12288;
                ry = $signed(16'($urandom_range(24576))) - 16'sd12288;
            end
            send_request(rx, ry, 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;
        while (catan_expected.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        $display("Covered %0d requests, %0d results (%0d saturated) in %0d cycles", sent,
                 received, saturations, cycles);
        $display("Phases: full rate, sender gaps, receiver stalls, both, long output hold-off");
        if (errors == 0) begin
            $display("[complex_arctangent_core] OK");
        end else begin
            $display("[complex_arctangent_core] ERROR");
        end
        $finish;
    end
endmodule

// File: complex_arctangent_core.f
hdl/catan_pkg.sv
hdl/catan_prep.sv
hdl/catan_cordic.sv
hdl/catan_post.sv
hdl/complex_arctangent_core.sv
hdl/catan_checker.sv
tb/tb_top.sv
